// ===== rtl/core/tga_pkg.sv =====
// shared types and constants for the targa run-length pixel decoder
package tga_pkg;

  localparam logic [1:0] FMT_16 = 2'd0;
  localparam logic [1:0] FMT_24 = 2'd1;
  localparam logic [1:0] FMT_32 = 2'd2;

  localparam logic [1:0] REG_PIXEL_FORMAT  = 2'd0;
  localparam logic [1:0] REG_RLE_ENABLE    = 2'd1;
  localparam logic [1:0] REG_ALPHA_ONE_BIT = 2'd2;

  localparam logic [7:0] REPEAT_BIAS = 8'd127;

  typedef enum logic [2:0] {
    MODE_HEADER = 3'b001,
    MODE_REPEAT = 3'b010,
    MODE_RAW    = 3'b100
  } tga_mode_e;

  typedef struct packed {
    logic [1:0] pixel_format;
    logic       rle_enable;
    logic       alpha_one_bit;
  } tga_cfg_t;

  typedef struct packed {
    logic [7:0] run;
    logic [7:0] last;
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
  } tga_event_t;

  typedef struct packed {
    logic [7:0] run_length;
    logic       alpha_present;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } tga_pixel_t;

endpackage

// ===== rtl/core/tga_rle_pixel_decoder.sv =====
// top level of the targa run-length pixel decoder
// a pixel result for the request with its last byte passes the parse event register, then the convert result register
// throughput: one input byte per cycle while the output is not back-pressured, set by the packet state update
// header bytes and non-final pixel bytes give no result
// reset clears packet state and byte position and loads format 24-bit, rle on,
// one-bit alpha off
module tga_rle_pixel_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // data_byte
  input  logic        s_axis_tuser_i,  // start_of_image
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // red, green, blue, alpha, run_length
  output logic        m_axis_tuser_o   // alpha_present
);
  import tga_pkg::*;

  tga_cfg_t   cfg_q;
  logic       ev_valid;
  logic       ev_ready;
  tga_event_t ev;
  tga_pixel_t pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_format  <= FMT_24;
      cfg_q.rle_enable    <= 1'b1;
      cfg_q.alpha_one_bit <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_PIXEL_FORMAT:  cfg_q.pixel_format  <= cfg_wdata_i;
        REG_RLE_ENABLE:    cfg_q.rle_enable    <= cfg_wdata_i[0];
        REG_ALPHA_ONE_BIT: cfg_q.alpha_one_bit <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  tga_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .data_byte_i (s_axis_tdata_i),
    .start_i     (s_axis_tuser_i),
    .ev_valid_o  (ev_valid),
    .ev_ready_i  (ev_ready),
    .ev_o        (ev)
  );

  tga_convert u_convert (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ev_valid_i  (ev_valid),
    .ev_ready_o  (ev_ready),
    .ev_i        (ev),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .pix_o       (pix)
  );

  assign m_axis_tdata_o = {pix.run_length, pix.alpha, pix.blue, pix.green, pix.red};
  assign m_axis_tuser_o = pix.alpha_present;

endmodule

// ===== rtl/core/tga_parse.sv =====
// packet parser and pixel byte collector with registered pixel event
module tga_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tga_pkg::tga_cfg_t   cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                start_i,
  output logic                ev_valid_o,
  input  logic                ev_ready_i,
  output tga_pkg::tga_event_t ev_o
);
  import tga_pkg::*;

  tga_mode_e  mode_q, mode_d;
  logic [6:0] raw_left_q, raw_left_d;
  logic [7:0] pending_q, pending_d;
  logic [1:0] idx_q, idx_d;
  logic [23:0] bytes_q, bytes_d;
  logic       ev_valid_q, ev_valid_d;
  tga_event_t ev_q, ev_d;

  tga_mode_e  mode_e;
  logic [6:0] raw_e;
  logic [7:0] pend_e;
  logic [1:0] idx_e;
  logic [1:0] last_pos;
  logic       accept;
  logic       emit;

  assign in_ready_o = ~ev_valid_q | ev_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    unique case (cfg_i.pixel_format)
      FMT_16:  last_pos = 2'd1;
      FMT_24:  last_pos = 2'd2;
      default: last_pos = 2'd3;
    endcase
  end

  always_comb begin
    mode_e = start_i ? MODE_HEADER : mode_q;
    raw_e  = start_i ? 7'd0 : raw_left_q;
    pend_e = start_i ? 8'd0 : pending_q;
    idx_e  = start_i ? 2'd0 : idx_q;

    mode_d     = mode_q;
    raw_left_d = raw_left_q;
    pending_d  = pending_q;
    idx_d      = idx_q;
    bytes_d    = bytes_q;
    emit       = 1'b0;
    ev_d       = ev_q;

    if (accept) begin
      mode_d     = mode_e;
      raw_left_d = raw_e;
      pending_d  = pend_e;
      idx_d      = idx_e;
      if (cfg_i.rle_enable && mode_e != MODE_REPEAT && mode_e != MODE_RAW) begin
        if (data_byte_i[7]) begin
          pending_d = data_byte_i - REPEAT_BIAS;
          mode_d    = MODE_REPEAT;
        end else begin
          raw_left_d = data_byte_i[6:0];
          mode_d     = MODE_RAW;
        end
        idx_d = 2'd0;
      end else if (idx_e < last_pos) begin
        unique case (idx_e)
          2'd0:    bytes_d[7:0]   = data_byte_i;
          2'd1:    bytes_d[15:8]  = data_byte_i;
          default: bytes_d[23:16] = data_byte_i;
        endcase
        idx_d = idx_e + 2'd1;
      end else begin
        idx_d       = 2'd0;
        emit        = 1'b1;
        ev_d.b0     = bytes_q[7:0];
        ev_d.b1     = bytes_q[15:8];
        ev_d.b2     = bytes_q[23:16];
        ev_d.last   = data_byte_i;
        ev_d.run    = 8'd1;
        if (cfg_i.rle_enable) begin
          if (mode_e == MODE_REPEAT) begin
            ev_d.run = pend_e;
            mode_d   = MODE_HEADER;
          end else if (raw_e == 7'd0) begin
            mode_d = MODE_HEADER;
          end else begin
            raw_left_d = raw_e - 7'd1;
          end
        end
      end
    end

    ev_valid_d = emit | (ev_valid_q & ~ev_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_HEADER;
      raw_left_q <= 7'd0;
      pending_q  <= 8'd0;
      idx_q      <= 2'd0;
      ev_valid_q <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      raw_left_q <= raw_left_d;
      pending_q  <= pending_d;
      idx_q      <= idx_d;
      ev_valid_q <= ev_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    if (emit) begin
      ev_q <= ev_d;
    end
  end

  assign ev_valid_o = ev_valid_q;
  assign ev_o       = ev_q;

endmodule

// ===== rtl/core/tga_convert.sv =====
// bgr to rgb and alpha conversion with result register
module tga_convert (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tga_pkg::tga_cfg_t   cfg_i,
  input  logic                ev_valid_i,
  output logic                ev_ready_o,
  input  tga_pkg::tga_event_t ev_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tga_pkg::tga_pixel_t pix_o
);
  import tga_pkg::*;

  logic       out_valid_q, out_valid_d;
  tga_pixel_t pix_q, pix_d;
  logic       load;
  logic [4:0] r5, g5, b5;

  assign ev_ready_o = ~out_valid_q | out_ready_i;
  assign load       = ev_valid_i & ev_ready_o;

  assign r5 = ev_i.last[6:2];
  assign g5 = {ev_i.last[1:0], ev_i.b0[7:5]};
  assign b5 = ev_i.b0[4:0];

  always_comb begin
    pix_d.run_length    = ev_i.run;
    pix_d.alpha         = 8'hff;
    pix_d.alpha_present = 1'b0;
    unique case (cfg_i.pixel_format)
      FMT_16: begin
        pix_d.red   = {r5, r5[4:2]};
        pix_d.green = {g5, g5[4:2]};
        pix_d.blue  = {b5, b5[4:2]};
        if (cfg_i.alpha_one_bit) begin
          pix_d.alpha         = ev_i.last[7] ? 8'h00 : 8'hff;
          pix_d.alpha_present = 1'b1;
        end
      end
      FMT_24: begin
        pix_d.red   = ev_i.last;
        pix_d.green = ev_i.b1;
        pix_d.blue  = ev_i.b0;
      end
      default: begin
        pix_d.red           = ev_i.b2;
        pix_d.green         = ev_i.b1;
        pix_d.blue          = ev_i.b0;
        pix_d.alpha         = ev_i.last;
        pix_d.alpha_present = 1'b1;
      end
    endcase
  end

  assign out_valid_d = load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q <= pix_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pix_o       = pix_q;

endmodule
